// ----- sv/taie_pkg.sv -----
// Shared types and field layout for the Thumb-2 ADC immediate execute core.
package taie_pkg;

    localparam int unsigned XLEN        = 32;
    localparam int unsigned REG_IDX_W   = 4;
    localparam int unsigned FLAGS_W     = 4;
    localparam int unsigned IMM12_W     = 12;

    // Stream word widths, padded to whole bytes
    localparam int unsigned IN_DATA_W   = 72;
    localparam int unsigned OUT_DATA_W  = 48;

    // Input word layout
    localparam int unsigned IN_INSTR_LSB = 0;
    localparam int unsigned IN_RN_LSB    = 32;
    localparam int unsigned IN_CARRY_BIT = 64;
    localparam int unsigned IN_EXEC_BIT  = 65;

    // Instruction field positions
    localparam int unsigned INSTR_RD_LSB = 8;
    localparam int unsigned INSTR_S_BIT  = 20;
    localparam int unsigned INSTR_I_BIT  = 26;

    // Flag bit positions inside nzcv
    localparam int unsigned FLAG_N = 3;
    localparam int unsigned FLAG_Z = 2;
    localparam int unsigned FLAG_C = 1;
    localparam int unsigned FLAG_V = 0;

    // Replicated byte patterns, selected by imm12[9:8]
    typedef enum logic [1:0] {
        REP_BYTE   = 2'b00,
        REP_HALVES = 2'b01,
        REP_ODD    = 2'b10,
        REP_ALL    = 2'b11
    } rep_mode_t;

    // Decoded instruction handed from the decoder to the pipeline
    typedef struct packed {
        logic [XLEN-1:0]      imm;
        logic [REG_IDX_W-1:0] rd;
        logic                 set_flags;
    } decode_t;

endpackage

// ----- sv/taie_decode.sv -----
// Field decode and modified-immediate expansion for ADC immediate T1.
module taie_decode (
    input  logic [taie_pkg::XLEN-1:0] instr,
    output taie_pkg::decode_t         dec
);
    import taie_pkg::*;

    logic [IMM12_W-1:0]  imm12;
    logic [7:0]          imm8;
    logic [XLEN-1:0]     unrot;
    logic [4:0]          rot;
    logic [2*XLEN-1:0]   rot_pair;
    logic [2*XLEN-1:0]   rot_shift;
    logic [XLEN-1:0]     imm_exp;

    // Gather i:imm3:imm8
    assign imm12 = {instr[INSTR_I_BIT], instr[14:12], instr[7:0]};
    assign imm8  = imm12[7:0];

    // Rotated 1:imm7 form
    assign unrot     = {{(XLEN-8){1'b0}}, 1'b1, imm12[6:0]};
    assign rot       = imm12[11:7];
    assign rot_pair  = {unrot, unrot};
    assign rot_shift = rot_pair >> rot;

    // Pick a replicated pattern or the rotated constant
    always_comb
    begin
        if (imm12[11:10] == 2'b00)
        begin
            unique case (rep_mode_t'(imm12[9:8]))
                REP_BYTE:   imm_exp = {24'h0, imm8};
                REP_HALVES: imm_exp = {8'h0, imm8, 8'h0, imm8};
                REP_ODD:    imm_exp = {imm8, 8'h0, imm8, 8'h0};
                REP_ALL:    imm_exp = {imm8, imm8, imm8, imm8};
                default:    imm_exp = {24'h0, imm8};
            endcase
        end
        else
        begin
            imm_exp = rot_shift[XLEN-1:0];
        end
    end

    assign dec.imm       = imm_exp;
    assign dec.rd        = instr[INSTR_RD_LSB +: REG_IDX_W];
    assign dec.set_flags = instr[INSTR_S_BIT];

endmodule

// ----- sv/thumb_adc_immediate_execute_core.sv -----
// Top level: three-stage pipelined Thumb-2 ADC immediate execute core.
//
// Input channel s_axis: one word per instruction, carrying the instruction
// word, the Rn value, the current C flag and the execute enable.
// Output channel m_axis: one word per instruction with the sum, Rd, the
// register write strobe, new NZCV flags and the flag write strobe.
// Every accepted input word yields exactly one output word, in order.
//
// Pipeline: stage 1 decodes and expands the immediate, stage 2 does the
// 33-bit add, stage 3 forms the flags and holds the output word.
// Throughput is one word per cycle while the receiver holds m_axis_tready
// high.
//
// Reset clears all stage valid bits; the pipeline comes up empty and
// ready. When the receiver holds m_axis_tready low, stages fill up
// behind the output register and s_axis_tready drops only once all three
// are occupied; nothing is lost or repeated.
module thumb_adc_immediate_execute_core (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // [31:0] instr, [63:32] rn_value, [64] carry_in, [65] execute, [71:66] zero
    input  logic [taie_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // [31:0] sum_value, [35:32] dest_index, [36] reg_write, [40:37] nzcv,
    // [41] flags_write, [47:42] zero
    output logic [taie_pkg::OUT_DATA_W-1:0] m_axis_tdata
);
    import taie_pkg::*;

    logic [XLEN-1:0] in_instr;
    logic [XLEN-1:0] in_rn;
    decode_t         dec;

    // Stage 1 registers
    logic                 s1_valid_reg, s1_valid_next;
    logic [XLEN-1:0]      s1_imm_reg;
    logic [XLEN-1:0]      s1_rn_reg;
    logic                 s1_carry_reg;
    logic                 s1_exec_reg;
    logic                 s1_sflag_reg;
    logic [REG_IDX_W-1:0] s1_rd_reg;

    // Stage 2 registers
    logic                 s2_valid_reg, s2_valid_next;
    logic [XLEN:0]        s2_sum_reg;
    logic                 s2_a_msb_reg;
    logic                 s2_b_msb_reg;
    logic                 s2_exec_reg;
    logic                 s2_fw_reg;
    logic [REG_IDX_W-1:0] s2_rd_reg;

    // Stage 3 (output) registers
    logic                 s3_valid_reg, s3_valid_next;
    logic [XLEN-1:0]      s3_sum_reg;
    logic [REG_IDX_W-1:0] s3_rd_reg;
    logic                 s3_rw_reg;
    logic [FLAGS_W-1:0]   s3_nzcv_reg;
    logic                 s3_fw_reg;

    logic adv1, adv2, adv3;
    logic [XLEN:0]        sum_wide;
    logic [FLAGS_W-1:0]   nzcv_calc;
    logic [XLEN-1:0]      r2;

    assign in_instr = s_axis_tdata[IN_INSTR_LSB +: XLEN];
    assign in_rn    = s_axis_tdata[IN_RN_LSB +: XLEN];

    taie_decode u_decode (
        .instr (in_instr),
        .dec   (dec)
    );

    // Advance a stage when it is empty or the stage after it moves
    assign adv3 = !s3_valid_reg || m_axis_tready;
    assign adv2 = !s2_valid_reg || adv3;
    assign adv1 = !s1_valid_reg || adv2;
    assign s_axis_tready = adv1;

    assign s1_valid_next = adv1 ? s_axis_tvalid : s1_valid_reg;
    assign s2_valid_next = adv2 ? s1_valid_reg  : s2_valid_reg;
    assign s3_valid_next = adv3 ? s2_valid_reg  : s3_valid_reg;

    // Clear valid bits under reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
            s3_valid_reg <= s3_valid_next;
        end
    end

    // Stage 1: capture decoded fields and operands
    always_ff @(posedge clk)
    begin
        if (adv1)
        begin
            s1_imm_reg   <= dec.imm;
            s1_rd_reg    <= dec.rd;
            s1_sflag_reg <= dec.set_flags;
            s1_rn_reg    <= in_rn;
            s1_carry_reg <= s_axis_tdata[IN_CARRY_BIT];
            s1_exec_reg  <= s_axis_tdata[IN_EXEC_BIT];
        end
    end

    // Stage 2: three-input add with carry out
    assign sum_wide = {1'b0, s1_rn_reg} + {1'b0, s1_imm_reg}
                    + {{XLEN{1'b0}}, s1_carry_reg};

    always_ff @(posedge clk)
    begin
        if (adv2)
        begin
            s2_sum_reg   <= sum_wide;
            s2_a_msb_reg <= s1_rn_reg[XLEN-1];
            s2_b_msb_reg <= s1_imm_reg[XLEN-1];
            s2_exec_reg  <= s1_exec_reg;
            s2_fw_reg    <= s1_exec_reg & s1_sflag_reg;
            s2_rd_reg    <= s1_rd_reg;
        end
    end

    // Stage 3: form flags, zero them when not written
    assign r2 = s2_sum_reg[XLEN-1:0];

    always_comb
    begin
        nzcv_calc         = '0;
        nzcv_calc[FLAG_N] = r2[XLEN-1];
        nzcv_calc[FLAG_Z] = (r2 == '0);
        nzcv_calc[FLAG_C] = s2_sum_reg[XLEN];
        nzcv_calc[FLAG_V] = (s2_a_msb_reg ^ r2[XLEN-1]) & (s2_b_msb_reg ^ r2[XLEN-1]);
        if (!s2_fw_reg)
        begin
            nzcv_calc = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv3)
        begin
            s3_sum_reg  <= r2;
            s3_rd_reg   <= s2_rd_reg;
            s3_rw_reg   <= s2_exec_reg;
            s3_nzcv_reg <= nzcv_calc;
            s3_fw_reg   <= s2_fw_reg;
        end
    end

    assign m_axis_tvalid = s3_valid_reg;
    assign m_axis_tdata  = {6'h0, s3_fw_reg, s3_nzcv_reg, s3_rw_reg, s3_rd_reg, s3_sum_reg};

`ifndef NO_ASSERTIONS
    // Input stalls only when every stage is full and the output is blocked
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> (s1_valid_reg && s2_valid_reg && m_axis_tvalid && !m_axis_tready))
        else $error("input stalled while pipeline had room");

    // Flag write implies register write
    a_fw_rw: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && s3_fw_reg) |-> s3_rw_reg)
        else $error("flags written without register write");

    // Flags read as zero when not written
    a_nzcv_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !s3_fw_reg) |-> (s3_nzcv_reg == '0))
        else $error("nzcv nonzero without flag write");

    // Z flag agrees with the registered sum
    a_z_flag: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && s3_fw_reg) |-> (s3_nzcv_reg[FLAG_Z] == (s3_sum_reg == '0)))
        else $error("Z flag disagrees with sum");
`endif

endmodule

// ----- test/tb.sv -----
// Testbench for the Thumb-2 ADC immediate execute core: random stream check with a predictor.
module tb;

    timeunit 1ns;
    timeprecision 1ps;

    import taie_pkg::*;

    localparam int unsigned ADC_T1_BASE   = 32'hF140_0000;
    localparam int unsigned RANDOM_WORDS  = 2000;
    localparam int unsigned CYCLE_LIMIT   = 200000;
    localparam int unsigned IDLE_PERCENT  = 29;
    localparam int unsigned BUSY_FROM     = 900;
    localparam int unsigned BUSY_TO       = 1200;
    localparam int unsigned HOLDOFF_AT    = 400;
    localparam int unsigned HOLDOFF_LEN   = 300;
    localparam int unsigned SETTLE_CYCLES = 8;

    // One instruction word as offered on the input stream
    typedef struct {
        logic [XLEN-1:0] instr;
        logic [XLEN-1:0] rn_value;
        logic            carry_in;
        logic            execute;
        bit              drain_first;
    } adc_op_t;

    // One result word as seen on the output stream
    typedef struct {
        logic [XLEN-1:0]      sum_value;
        logic [REG_IDX_W-1:0] dest_index;
        logic                 reg_write;
        logic [FLAGS_W-1:0]   nzcv;
        logic                 flags_write;
    } adc_result_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;

    adc_op_t     pending_ops[$];
    adc_result_t expected_results[$];
    adc_op_t     offered_op;

    int unsigned words_sent = 0;
    int unsigned results_checked = 0;
    int unsigned flag_results = 0;
    int unsigned suppressed_results = 0;
    int unsigned error_count = 0;
    int unsigned cycle_count = 0;
    int unsigned holdoff_left = 0;
    bit          holdoff_done = 1'b0;

    thumb_adc_immediate_execute_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #5 clk = ~clk;

    // Expand i:imm3:imm8 into the 32-bit constant
    function automatic logic [XLEN-1:0] expand_modified_imm(logic [IMM12_W-1:0] imm12);
        logic [7:0]        b;
        logic [XLEN-1:0]   unrot;
        logic [2*XLEN-1:0] doubled;
        b = imm12[7:0];
        if (imm12[11:10] == 2'b00)
        begin
            case (rep_mode_t'(imm12[9:8]))
                REP_BYTE:   return {24'b0, b};
                REP_HALVES: return {8'b0, b, 8'b0, b};
                REP_ODD:    return {b, 8'b0, b, 8'b0};
                default:    return {b, b, b, b};
            endcase
        end
        unrot = {24'b0, 1'b1, imm12[6:0]};
        doubled = {unrot, unrot} >> imm12[11:7];
        return doubled[XLEN-1:0];
    endfunction

    // Work out the result word that one instruction must produce
    function automatic adc_result_t predict_adc(adc_op_t op);
        adc_result_t     res;
        logic [XLEN-1:0] imm;
        logic [XLEN:0]   wide;
        logic            ovf;
        imm = expand_modified_imm({op.instr[INSTR_I_BIT], op.instr[14:12], op.instr[7:0]});
        wide = {1'b0, op.rn_value} + {1'b0, imm} + {{XLEN{1'b0}}, op.carry_in};
        ovf = (op.rn_value[XLEN-1] ^ wide[XLEN-1]) & (imm[XLEN-1] ^ wide[XLEN-1]);
        res.sum_value = wide[XLEN-1:0];
        res.dest_index = op.instr[INSTR_RD_LSB +: REG_IDX_W];
        res.reg_write = op.execute;
        res.flags_write = op.execute & op.instr[INSTR_S_BIT];
        res.nzcv = '0;
        if (res.flags_write)
        begin
            res.nzcv[FLAG_N] = wide[XLEN-1];
            res.nzcv[FLAG_Z] = (wide[XLEN-1:0] == '0);
            res.nzcv[FLAG_C] = wide[XLEN];
            res.nzcv[FLAG_V] = ovf;
        end
        return res;
    endfunction

    // Build an ADC T1 word from its fields, Rn index random
    function automatic logic [XLEN-1:0] adc_word(logic i_bit, logic [2:0] imm3, logic [7:0] imm8,
                                                 logic [3:0] rd, logic s_bit);
        logic [XLEN-1:0] w;
        w = ADC_T1_BASE;
        w[INSTR_I_BIT] = i_bit;
        w[INSTR_S_BIT] = s_bit;
        w[19:16] = 4'($urandom);
        w[14:12] = imm3;
        w[INSTR_RD_LSB +: REG_IDX_W] = rd;
        w[7:0] = imm8;
        return w;
    endfunction

    function automatic void queue_op(logic [XLEN-1:0] instr, logic [XLEN-1:0] rn,
                                     logic carry, logic exec, bit drain);
        adc_op_t op;
        op.instr = instr;
        op.rn_value = rn;
        op.carry_in = carry;
        op.execute = exec;
        op.drain_first = drain;
        pending_ops.push_back(op);
    endfunction

    // Random idling, switched off for one long stretch of the run
    function automatic bit take_idle();
        if (words_sent >= BUSY_FROM && words_sent < BUSY_TO)
            return 1'b0;
        return $urandom_range(0, 99) < IDLE_PERCENT;
    endfunction

    // Driver: predict accepted words, then offer the next pending one
    always @(posedge clk or negedge rst_n)
    begin
        bit load;
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata <= '0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                expected_results.push_back(predict_adc(offered_op));
                words_sent++;
            end
            if (!s_axis_tvalid || s_axis_tready)
            begin
                load = pending_ops.size() != 0;
                // hold a drain-marked word until the pipeline has emptied
                if (load && pending_ops[0].drain_first && expected_results.size() != 0)
                    load = 1'b0;
                if (load && take_idle())
                    load = 1'b0;
                if (load)
                begin
                    offered_op = pending_ops.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata <= {6'b0, offered_op.execute, offered_op.carry_in,
                                     offered_op.rn_value, offered_op.instr};
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Hold-off counter: start one long stall so the pipeline backs up into the input
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            holdoff_done <= 1'b0;
            holdoff_left <= 0;
        end
        else if (!holdoff_done && results_checked >= HOLDOFF_AT)
        begin
            holdoff_done <= 1'b1;
            holdoff_left <= HOLDOFF_LEN;
        end
        else if (holdoff_left != 0)
            holdoff_left <= holdoff_left - 1;
    end

    // Monitor: check each result word against the oldest expectation
    always @(posedge clk or negedge rst_n)
    begin
        adc_result_t want;
        adc_result_t got;
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.sum_value = m_axis_tdata[31:0];
                got.dest_index = m_axis_tdata[35:32];
                got.reg_write = m_axis_tdata[36];
                got.nzcv = m_axis_tdata[40:37];
                got.flags_write = m_axis_tdata[41];
                if (expected_results.size() == 0)
                begin
                    $error("unexpected result word %h", m_axis_tdata);
                    error_count++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (got.sum_value !== want.sum_value)
                    begin
                        $error("sum_value: expected %h, got %h", want.sum_value, got.sum_value);
                        error_count++;
                    end
                    if (got.dest_index !== want.dest_index)
                    begin
                        $error("dest_index: expected %0d, got %0d",
                               want.dest_index, got.dest_index);
                        error_count++;
                    end
                    if (got.reg_write !== want.reg_write)
                    begin
                        $error("reg_write: expected %b, got %b", want.reg_write, got.reg_write);
                        error_count++;
                    end
                    if (got.nzcv !== want.nzcv)
                    begin
                        $error("nzcv: expected %b, got %b", want.nzcv, got.nzcv);
                        error_count++;
                    end
                    if (got.flags_write !== want.flags_write)
                    begin
                        $error("flags_write: expected %b, got %b",
                               want.flags_write, got.flags_write);
                        error_count++;
                    end
                    if (want.flags_write)
                        flag_results++;
                    if (!want.reg_write)
                        suppressed_results++;
                end
                results_checked++;
            end
            // hold ready low while the hold-off runs, otherwise idle at random
            if (holdoff_left != 0)
                m_axis_tready <= 1'b0;
            else
                m_axis_tready <= !take_idle();
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("tb: errors");
            $finish;
        end
    end

    // Stimulus, reset and end of run
    initial
    begin
        logic [XLEN-1:0] instr;
        logic [XLEN-1:0] rn;
        logic [XLEN-1:0] imm;
        logic            carry;
        int unsigned     pick;

        // replicated patterns with a full and a zero byte
        queue_op(adc_word(1'b0, 3'b000, 8'hFF, 4'd0, 1'b1), 32'h0000_0001, 1'b0, 1'b1, 1'b0);
        queue_op(adc_word(1'b0, 3'b001, 8'hFF, 4'd1, 1'b1), 32'h1234_5678, 1'b1, 1'b1, 1'b0);
        queue_op(adc_word(1'b0, 3'b010, 8'hA5, 4'd2, 1'b1), 32'h8000_0000, 1'b0, 1'b1, 1'b0);
        queue_op(adc_word(1'b0, 3'b011, 8'hFF, 4'd3, 1'b1), 32'h0000_0000, 1'b1, 1'b1, 1'b0);
        queue_op(adc_word(1'b0, 3'b001, 8'h00, 4'd4, 1'b1), 32'h0000_0000, 1'b0, 1'b1, 1'b0);
        queue_op(adc_word(1'b0, 3'b010, 8'h00, 4'd5, 1'b1), 32'hFFFF_FFFF, 1'b1, 1'b1, 1'b0);
        queue_op(adc_word(1'b0, 3'b011, 8'h00, 4'd6, 1'b0), 32'hDEAD_BEEF, 1'b1, 1'b1, 1'b0);
        // rotated constants, smallest and largest rotation
        queue_op(adc_word(1'b0, 3'b100, 8'h7F, 4'd7, 1'b1), 32'h7FFF_FFFF, 1'b0, 1'b1, 1'b0);
        queue_op(adc_word(1'b1, 3'b111, 8'hFF, 4'd8, 1'b1), 32'hFFFF_FFFF, 1'b1, 1'b1, 1'b0);
        queue_op(adc_word(1'b1, 3'b000, 8'h00, 4'd9, 1'b1), 32'h0000_0000, 1'b0, 1'b1, 1'b0);
        // signed overflow and unsigned wrap to zero
        queue_op(adc_word(1'b0, 3'b000, 8'h01, 4'd10, 1'b1), 32'h7FFF_FFFF, 1'b0, 1'b1, 1'b0);
        queue_op(adc_word(1'b0, 3'b000, 8'h00, 4'd11, 1'b1), 32'h7FFF_FFFF, 1'b1, 1'b1, 1'b0);
        queue_op(adc_word(1'b0, 3'b000, 8'h01, 4'd12, 1'b1), 32'hFFFF_FFFF, 1'b0, 1'b1, 1'b0);
        queue_op(adc_word(1'b0, 3'b000, 8'h00, 4'd0, 1'b1), 32'h0000_0000, 1'b0, 1'b1, 1'b0);
        queue_op(adc_word(1'b1, 3'b000, 8'h00, 4'd1, 1'b1), 32'h8000_0000, 1'b0, 1'b1, 1'b0);
        // suppressed execution, with and without S
        queue_op(adc_word(1'b0, 3'b000, 8'hFF, 4'd2, 1'b1), 32'hFFFF_FFFF, 1'b1, 1'b0, 1'b0);
        queue_op(adc_word(1'b1, 3'b101, 8'h3C, 4'd3, 1'b0), 32'h5555_5555, 1'b0, 1'b0, 1'b0);
        // reserved destinations are reported as given
        queue_op(adc_word(1'b0, 3'b000, 8'h10, 4'd13, 1'b1), 32'h0000_1000, 1'b0, 1'b1, 1'b0);
        queue_op(adc_word(1'b0, 3'b000, 8'h20, 4'd15, 1'b1), 32'h0000_2000, 1'b1, 1'b1, 1'b0);
        // words that are not ADC at all still decode as ADC
        queue_op(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b1, 1'b0);
        queue_op(32'h0000_0000, 32'h0000_0000, 1'b0, 1'b1, 1'b0);
        queue_op(32'hA5A5_5A5A, 32'h0F0F_F0F0, 1'b1, 1'b1, 1'b0);

        // random words, mostly well-formed, drain pauses sprinkled in
        for (int unsigned k = 0; k < RANDOM_WORDS; k++)
        begin
            if ($urandom_range(0, 99) < 80)
                instr = adc_word(1'($urandom), 3'($urandom), 8'($urandom),
                                 4'($urandom), 1'($urandom_range(0, 99) < 60));
            else
                instr = $urandom;
            carry = 1'($urandom);
            pick = $urandom_range(0, 99);
            imm = expand_modified_imm({instr[INSTR_I_BIT], instr[14:12], instr[7:0]});
            if (pick < 10)
                rn = 32'h0 - imm - {31'b0, carry};
            else if (pick < 15)
                rn = 32'h7FFF_FFFF - imm;
            else if (pick < 25)
            begin
                case ($urandom_range(0, 3))
                    0:       rn = 32'h0000_0000;
                    1:       rn = 32'hFFFF_FFFF;
                    2:       rn = 32'h7FFF_FFFF;
                    default: rn = 32'h8000_0000;
                endcase
            end
            else
                rn = $urandom;
            queue_op(instr, rn, carry, 1'($urandom_range(0, 99) < 85),
                     (k == 500) || (k == 1500));
        end

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_ops.size() != 0 || s_axis_tvalid)
            @(posedge clk);
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("tb: %0d words sent, %0d results checked", words_sent, results_checked);
        $display("tb: %0d with flag writes, %0d suppressed", flag_results, suppressed_results);
        if (error_count == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

endmodule
